// File: src/i2cm_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// I2C master byte engine package
// Phase codes, request codes and the engine state record.
// ----------------------------------------------------------------------------
package i2cm_pkg;

	localparam logic [15:0] PHASE_TICKS_RST = 16'd10;

	localparam logic [2:0] REQ_NONE  = 3'd0;
	localparam logic [2:0] REQ_START = 3'd1;
	localparam logic [2:0] REQ_STOP  = 3'd2;
	localparam logic [2:0] REQ_WRITE = 3'd3;
	localparam logic [2:0] REQ_READ  = 3'd4;

	typedef enum logic [4:0] {
		PH_IDLE    = 5'd0,
		ST_SCL_REL = 5'd1,
		ST_SDA_LOW = 5'd2,
		SP_SDA_LOW = 5'd3,
		SP_SCL_REL = 5'd4,
		SP_SDA_REL = 5'd5,
		WR_SCL_LOW = 5'd6,
		WR_SDA_SET = 5'd7,
		WR_SCL_REL = 5'd8,
		WR_WAIT    = 5'd9,
		WA_SCL_LOW = 5'd10,
		WA_SDA_REL = 5'd11,
		WA_SCL_REL = 5'd12,
		WA_WAIT    = 5'd13,
		WA_SCL_END = 5'd14,
		RD_SCL_LOW = 5'd15,
		RD_SCL_REL = 5'd16,
		RD_WAIT    = 5'd17,
		RA_SCL_LOW = 5'd18,
		RA_SDA_SET = 5'd19,
		RA_SCL_REL = 5'd20,
		RA_WAIT    = 5'd21,
		RA_SCL_END = 5'd22
	} phase_t;

	typedef struct packed {
		phase_t      phase;
		logic [2:0]  bit_count;
		logic [15:0] delay_count;
		logic [7:0]  shift_byte;
		logic        ack_to_send;
		logic        scl_drive;
		logic        sda_drive;
		logic [7:0]  last_read;
		logic        last_ack;
	} eng_state_t;

	function automatic logic is_wait(input phase_t p);
		return (p == WR_WAIT) || (p == WA_WAIT) || (p == RD_WAIT) || (p == RA_WAIT);
	endfunction

endpackage

// File: src/i2c_master_byte_engine_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// I2C master byte engine
// Open-drain I2C master driven one tick per stream transaction.
// ----------------------------------------------------------------------------
// Each input transaction is one bus tick: s_tuser carries the request (none,
// start, stop, write byte, read byte), s_tdata the write byte, the ACK choice
// for a read and the sampled SDA and SCL levels. Every accepted tick yields
// exactly one output transaction with the SCL/SDA pull-low drives and status,
// valid on m_tdata the cycle after the input is taken.
// Throughput is one tick per cycle: the step logic sits between the engine
// state register and the output register, and s_tready stays high while the
// output register is empty or being drained.
// If the receiver stalls, the output register holds its transaction and
// s_tready drops, so the engine does not advance until the result is taken.
// phase_ticks is written on the cfg channel (always ready); the user must write
// it only while idle (not enforced). Timed steps last that many ticks, zero as one.
// Reset releases both lines, returns the engine to idle, clears read data
// and ACK status, loads phase_ticks with 10 and empties the output register.
// ----------------------------------------------------------------------------
module i2c_master_byte_engine_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	// [7:0] write_data, [8] send_ack, [9] sda_in, [10] scl_in, [15:11] zero
	input  logic [15:0] s_tdata,
	// [2:0] req_type
	input  logic [2:0]  s_tuser,
	output logic        m_tvalid,
	input  logic        m_tready,
	// [0] scl_low, [1] sda_low, [2] busy_res, [3] done_res, [11:4] read_data,
	// [12] ack_received, [13] cmd_ignored, [15:14] zero
	output logic [15:0] m_tdata,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [15:0] cfg_data
);

	i2cm_pkg::eng_state_t st_q;
	i2cm_pkg::eng_state_t st_nxt;
	logic [15:0]          phase_ticks_q;
	logic                 done;
	logic                 ignored;
	logic                 in_acc;
	logic [15:0]          res_s1;

	assign cfg_ready = 1'b1;
	assign s_tready  = !m_tvalid || m_tready;
	assign in_acc    = s_tvalid && s_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_ticks_q <= i2cm_pkg::PHASE_TICKS_RST;
		end else if (cfg_valid) begin
			phase_ticks_q <= cfg_data;
		end
	end

	i2cm_step u_step (
		.st_cur      (st_q),
		.phase_ticks (phase_ticks_q),
		.req_type    (s_tuser),
		.write_data  (s_tdata[7:0]),
		.send_ack    (s_tdata[8]),
		.sda_in      (s_tdata[9]),
		.scl_in      (s_tdata[10]),
		.st_nxt      (st_nxt),
		.done        (done),
		.ignored     (ignored)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= '{phase: i2cm_pkg::PH_IDLE, default: '0};
		end else if (in_acc) begin
			st_q <= st_nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid <= 1'b0;
		end else if (s_tready) begin
			m_tvalid <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			res_s1 <= {2'b00, ignored, st_nxt.last_ack, st_nxt.last_read, done,
				(st_nxt.phase != i2cm_pkg::PH_IDLE), st_nxt.sda_drive, st_nxt.scl_drive};
		end
	end

	assign m_tdata = res_s1;

	// a finishing tick leaves the engine idle
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[3] |-> !m_tdata[2])
		else $error("done reported while still busy");

	// no command is flagged as dropped when the engine was idle
	a_ign_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc && (st_q.phase == i2cm_pkg::PH_IDLE) |=> !m_tdata[13])
		else $error("command dropped while idle");

	// a stretched clock holds the wait step
	a_wait_hold: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc && i2cm_pkg::is_wait(st_q.phase) && !s_tdata[10] |=> $stable(st_q))
		else $error("wait step left while SCL low");

	// an idle tick with no request leaves the line drives alone
	a_idle_drv: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc && (st_q.phase == i2cm_pkg::PH_IDLE) && (s_tuser == i2cm_pkg::REQ_NONE)
		|=> $stable(st_q.scl_drive) && $stable(st_q.sda_drive))
		else $error("drives changed on an idle tick");

endmodule

// File: src/i2cm_step.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// I2C master step logic
// Next engine state and status flags for one tick, from the current state,
// the tick's request and the sampled line levels.
// ----------------------------------------------------------------------------
module i2cm_step (
	input  i2cm_pkg::eng_state_t st_cur,
	input  logic [15:0]          phase_ticks,
	input  logic [2:0]           req_type,
	input  logic [7:0]           write_data,
	input  logic                 send_ack,
	input  logic                 sda_in,
	input  logic                 scl_in,
	output i2cm_pkg::eng_state_t st_nxt,
	output logic                 done,
	output logic                 ignored
);

	logic [15:0] ticks_eff;
	logic        fin;

	assign ticks_eff = (phase_ticks == 16'd0) ? 16'd1 : phase_ticks;

	function automatic i2cm_pkg::eng_state_t enter_ph(
		input i2cm_pkg::eng_state_t s,
		input i2cm_pkg::phase_t     p,
		input logic [15:0]          tk
	);
		i2cm_pkg::eng_state_t r;
		r = s;
		r.phase = p;
		unique case (p)
			i2cm_pkg::ST_SCL_REL, i2cm_pkg::SP_SCL_REL, i2cm_pkg::WR_SCL_REL,
			i2cm_pkg::WA_SCL_REL, i2cm_pkg::RD_SCL_REL, i2cm_pkg::RA_SCL_REL: begin
				r.scl_drive = 1'b0;
			end
			i2cm_pkg::ST_SDA_LOW, i2cm_pkg::SP_SDA_LOW: begin
				r.sda_drive = 1'b1;
			end
			i2cm_pkg::SP_SDA_REL, i2cm_pkg::WA_SDA_REL: begin
				r.sda_drive = 1'b0;
			end
			i2cm_pkg::WR_SCL_LOW, i2cm_pkg::WA_SCL_LOW, i2cm_pkg::WA_SCL_END,
			i2cm_pkg::RA_SCL_LOW, i2cm_pkg::RA_SCL_END: begin
				r.scl_drive = 1'b1;
			end
			i2cm_pkg::RD_SCL_LOW: begin
				r.scl_drive = 1'b1;
				r.sda_drive = 1'b0;
			end
			i2cm_pkg::WR_SDA_SET: begin
				r.sda_drive = ~s.shift_byte[7];
			end
			i2cm_pkg::RA_SDA_SET: begin
				r.sda_drive = s.ack_to_send;
			end
			default: begin
			end
		endcase
		if (!i2cm_pkg::is_wait(p)) begin
			r.delay_count = tk;
		end
		return r;
	endfunction

	function automatic i2cm_pkg::eng_state_t advance_ph(
		input i2cm_pkg::eng_state_t s,
		input logic                 sda,
		input logic [15:0]          tk
	);
		i2cm_pkg::eng_state_t r;
		r = s;
		unique case (s.phase)
			i2cm_pkg::ST_SDA_LOW, i2cm_pkg::SP_SDA_REL, i2cm_pkg::WA_SCL_END: begin
				r.phase = i2cm_pkg::PH_IDLE;
			end
			i2cm_pkg::RA_SCL_END: begin
				r.last_read = s.shift_byte;
				r.sda_drive = 1'b0;
				r.phase     = i2cm_pkg::PH_IDLE;
			end
			i2cm_pkg::WR_WAIT: begin
				r.shift_byte = {s.shift_byte[6:0], 1'b0};
				r.bit_count  = s.bit_count + 3'd1;
				r = enter_ph(r, (r.bit_count == 3'd0) ? i2cm_pkg::WA_SCL_LOW :
					i2cm_pkg::WR_SCL_LOW, tk);
			end
			i2cm_pkg::WA_WAIT: begin
				r.last_ack = ~sda;
				r = enter_ph(r, i2cm_pkg::WA_SCL_END, tk);
			end
			i2cm_pkg::RD_WAIT: begin
				r.shift_byte = {s.shift_byte[6:0], sda};
				r.bit_count  = s.bit_count + 3'd1;
				r = enter_ph(r, (r.bit_count == 3'd0) ? i2cm_pkg::RA_SCL_LOW :
					i2cm_pkg::RD_SCL_LOW, tk);
			end
			default: begin
				if (s.phase >= i2cm_pkg::ST_SCL_REL && s.phase < i2cm_pkg::RA_SCL_END) begin
					r = enter_ph(r, i2cm_pkg::phase_t'(s.phase + 5'd1), tk);
				end else begin
					r.phase = i2cm_pkg::PH_IDLE;
				end
			end
		endcase
		return r;
	endfunction

	// steps that end a command on leaving
	assign fin = (st_cur.phase == i2cm_pkg::ST_SDA_LOW) || (st_cur.phase == i2cm_pkg::SP_SDA_REL)
		|| (st_cur.phase == i2cm_pkg::WA_SCL_END) || (st_cur.phase == i2cm_pkg::RA_SCL_END);

	always_comb begin
		st_nxt  = st_cur;
		done    = 1'b0;
		ignored = 1'b0;
		if (st_cur.phase == i2cm_pkg::PH_IDLE) begin
			unique case (req_type)
				i2cm_pkg::REQ_START: begin
					st_nxt = enter_ph(st_cur, i2cm_pkg::ST_SCL_REL, ticks_eff);
				end
				i2cm_pkg::REQ_STOP: begin
					st_nxt = enter_ph(st_cur, i2cm_pkg::SP_SDA_LOW, ticks_eff);
				end
				i2cm_pkg::REQ_WRITE: begin
					st_nxt            = st_cur;
					st_nxt.shift_byte = write_data;
					st_nxt.bit_count  = 3'd0;
					st_nxt = enter_ph(st_nxt, i2cm_pkg::WR_SCL_LOW, ticks_eff);
				end
				i2cm_pkg::REQ_READ: begin
					st_nxt             = st_cur;
					st_nxt.shift_byte  = 8'd0;
					st_nxt.bit_count   = 3'd0;
					st_nxt.ack_to_send = send_ack;
					st_nxt = enter_ph(st_nxt, i2cm_pkg::RD_SCL_LOW, ticks_eff);
				end
				default: begin
				end
			endcase
		end else begin
			ignored = (req_type == i2cm_pkg::REQ_START) || (req_type == i2cm_pkg::REQ_STOP)
				|| (req_type == i2cm_pkg::REQ_WRITE) || (req_type == i2cm_pkg::REQ_READ);
			if (st_cur.phase > i2cm_pkg::RA_SCL_END) begin
				st_nxt.phase = i2cm_pkg::PH_IDLE;
			end else if (i2cm_pkg::is_wait(st_cur.phase)) begin
				// hold until the slave lets the clock go high
				if (scl_in) begin
					st_nxt = advance_ph(st_cur, sda_in, ticks_eff);
					done   = fin;
				end
			end else if (st_cur.delay_count <= 16'd1) begin
				st_nxt             = st_cur;
				st_nxt.delay_count = 16'd0;
				st_nxt = advance_ph(st_nxt, sda_in, ticks_eff);
				done   = fin;
			end else begin
				st_nxt.delay_count = st_cur.delay_count - 16'd1;
			end
		end
	end

endmodule
